>>> rtl/ati_pkg.sv
// shared constants, register codes and the cordic angle table for the tilt block
package ati_pkg;

    // defaults of the top level parameters
    localparam int DEF_SAMPLE_WIDTH  = 16;
    localparam int DEF_CORDIC_STAGES = 16;

    // cordic angle format: degrees scaled by 2^16
    localparam int ZW       = 26;
    localparam int IN_SCALE = 24;
    localparam logic signed [ZW-1:0] DEG90 = 26'sd5898240;

    // cordic gain K in q24, negated for the pitch y operand
    localparam logic signed [25:0] NEG_GAIN_Q24 = -26'sd27628053;

    // hundredths conversion
    localparam int HW = 34;
    localparam logic signed [HW-1:0] HUND_SCALE = 34'sd100;
    localparam logic [17:0] PITCH_LIM = 18'd9000;
    localparam logic [17:0] ROLL_LIM  = 18'd18000;

    // inclination root
    localparam int SQ_W   = 30;
    localparam int ROOT_W = 15;

    // configuration port
    localparam int CFG_W  = 15;
    localparam int CFG_AW = 3;
    localparam logic [CFG_AW-1:0] REG_OFFSET   = 3'd0;
    localparam logic [CFG_AW-1:0] REG_LOW_BAND = 3'd1;
    localparam logic [CFG_AW-1:0] REG_HIGH_BAND = 3'd2;
    localparam logic [CFG_AW-1:0] REG_FOLD_THR = 3'd3;
    localparam logic [CFG_AW-1:0] REG_FOLD_AMT = 3'd4;

    localparam logic [10:0] RST_OFFSET    = 11'd500;
    localparam logic [13:0] RST_LOW_BAND  = 14'd1500;
    localparam logic [14:0] RST_HIGH_BAND = 15'd8500;
    localparam logic [14:0] RST_FOLD_THR  = 15'd9500;
    localparam logic [14:0] RST_FOLD_AMT  = 15'd9000;

    // round(atan(2^-i) in degrees * 2^16)
    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:  v = 26'sd2949120;
            1:  v = 26'sd1740967;
            2:  v = 26'sd919879;
            3:  v = 26'sd466945;
            4:  v = 26'sd234379;
            5:  v = 26'sd117304;
            6:  v = 26'sd58666;
            7:  v = 26'sd29335;
            8:  v = 26'sd14668;
            9:  v = 26'sd7334;
            10: v = 26'sd3667;
            11: v = 26'sd1833;
            12: v = 26'sd917;
            13: v = 26'sd458;
            14: v = 26'sd229;
            15: v = 26'sd115;
            16: v = 26'sd57;
            17: v = 26'sd29;
            18: v = 26'sd14;
            19: v = 26'sd7;
            20: v = 26'sd4;
            21: v = 26'sd2;
            22: v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/accel_tilt_inclination.sv
// top level: pitch, roll and corrected inclination from one accelerometer sample
// One sample enters per clock unless the pipeline holds; its result passes through two
// input stages, the roll cordic and then the pitch cordic (each one pre-rotation plus
// one stage per rotation), two stages of conversion to hundredths, two of squaring and
// summing, one per root bit (15), and two of correction and folding. The whole pipeline
// advances together; it holds only while a result waits on m_tready, and s_tready then
// falls in the same cycle.
// Configuration registers reset to 500, 1500, 8500, 9500 and 9000 and should be
// written while no item is in flight.
module accel_tilt_inclination #(
    parameter int SAMPLE_WIDTH  = ati_pkg::DEF_SAMPLE_WIDTH,
    parameter int CORDIC_STAGES = ati_pkg::DEF_CORDIC_STAGES
) (
    input  logic aclk,
    input  logic aresetn,
    // s_tdata fields from bit 0: accel_x, accel_y, accel_z
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
    // m_tdata fields from bit 0: pitch_angle, roll_angle, total_inclination
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    input  logic                        cfg_wr_en,
    input  logic [ati_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [ati_pkg::CFG_W-1:0]   cfg_wdata
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int W  = SAMPLE_WIDTH + 28;
    localparam int ZW = ati_pkg::ZW;
    localparam int HW = ati_pkg::HW;
    localparam int QW = ati_pkg::SQ_W;
    localparam int RW = ati_pkg::ROOT_W;

    // global pipeline advance
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // configuration registers
    logic [10:0] offset_reg;
    logic [13:0] low_band_reg;
    logic [14:0] high_band_reg;
    logic [14:0] fold_thr_reg;
    logic [14:0] fold_amt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg    <= ati_pkg::RST_OFFSET;
            low_band_reg  <= ati_pkg::RST_LOW_BAND;
            high_band_reg <= ati_pkg::RST_HIGH_BAND;
            fold_thr_reg  <= ati_pkg::RST_FOLD_THR;
            fold_amt_reg  <= ati_pkg::RST_FOLD_AMT;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                ati_pkg::REG_OFFSET:    offset_reg    <= cfg_wdata[10:0];
                ati_pkg::REG_LOW_BAND:  low_band_reg  <= cfg_wdata[13:0];
                ati_pkg::REG_HIGH_BAND: high_band_reg <= cfg_wdata;
                ati_pkg::REG_FOLD_THR:  fold_thr_reg  <= cfg_wdata;
                ati_pkg::REG_FOLD_AMT:  fold_amt_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // valid bits of the stages outside the cordics
    logic            v0_reg, v1_reg, h1_vld_reg, h2_vld_reg, q1_vld_reg;
    logic [RW:0]     sq_vld_reg;
    logic            c1_vld_reg, out_vld_reg;
    logic            roll_vld, pitch_vld;

    // stage 0: capture the sample
    logic signed [SW-1:0] ax_reg, ay_reg, az_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg <= s_tdata[SW-1:0];
            ay_reg <= s_tdata[2*SW-1:SW];
            az_reg <= s_tdata[3*SW-1:2*SW];
        end
    end

    // stage 1: scale to q24, gain-match x, zero-vector flags
    logic signed [W-1:0] rx_reg, ry_reg, py1_reg;
    logic                ax_zero1_reg, roll_zero1_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            rx_reg         <= W'(az_reg) <<< ati_pkg::IN_SCALE;
            ry_reg         <= W'(ay_reg) <<< ati_pkg::IN_SCALE;
            py1_reg        <= W'(ax_reg * ati_pkg::NEG_GAIN_Q24);
            ax_zero1_reg   <= (ax_reg == '0);
            roll_zero1_reg <= (ay_reg == '0) && (az_reg == '0);
        end
    end

    // roll cordic
    logic signed [W-1:0]  roll_x;
    logic signed [ZW-1:0] roll_z;
    logic [W+1:0]         roll_sb;
    ati_cordic #(.W(W), .STAGES(CORDIC_STAGES), .SBW(W+2)) u_roll (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_vld(v1_reg),
        .x_in(rx_reg), .y_in(ry_reg),
        .sb_in({ax_zero1_reg, roll_zero1_reg, py1_reg}),
        .out_vld(roll_vld), .x_out(roll_x), .z_out(roll_z), .sb_out(roll_sb)
    );

    // pitch operands: roll magnitude and scaled -ax
    logic                 roll_zero, pitch_zero;
    logic signed [W-1:0]  pitch_xin;
    logic signed [ZW-1:0] roll_zf;
    assign roll_zero  = roll_sb[W];
    assign pitch_zero = roll_sb[W+1] && roll_zero;
    assign pitch_xin  = roll_zero ? '0 : roll_x;
    assign roll_zf    = roll_zero ? '0 : roll_z;

    // pitch cordic
    logic signed [ZW-1:0] pitch_z;
    logic [ZW:0]          pitch_sb;
    ati_cordic #(.W(W), .STAGES(CORDIC_STAGES), .SBW(ZW+1)) u_pitch (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_vld(roll_vld),
        .x_in(pitch_xin), .y_in(roll_sb[W-1:0]),
        .sb_in({pitch_zero, roll_zf}),
        .out_vld(pitch_vld), .x_out(), .z_out(pitch_z), .sb_out(pitch_sb)
    );

    // h1: scale angles by 100
    logic signed [ZW-1:0] pitch_zf;
    logic signed [HW-1:0] tp_reg, tr_reg;
    assign pitch_zf = pitch_sb[ZW] ? '0 : pitch_z;
    always_ff @(posedge aclk) begin
        if (en) begin
            tp_reg <= HW'(pitch_zf) * ati_pkg::HUND_SCALE;
            tr_reg <= HW'($signed(pitch_sb[ZW-1:0])) * ati_pkg::HUND_SCALE;
        end
    end

    // round half away from zero, clamp magnitude
    function automatic logic signed [18:0] to_hund(input logic signed [HW-1:0] t,
                                                   input logic [17:0] lim);
        logic [HW-1:0] mag;
        logic [HW-1:0] rnd;
        logic [17:0]   h;
        mag = t[HW-1] ? HW'(-t) : HW'(t);
        rnd = (mag + HW'(32768)) >> 16;
        h   = (rnd > HW'(lim)) ? lim : rnd[17:0];
        return t[HW-1] ? -$signed({1'b0, h}) : $signed({1'b0, h});
    endfunction

    // h2: angles in hundredths
    logic signed [14:0] pitch2_reg;
    logic signed [15:0] roll2_reg;
    logic signed [18:0] pitch_h, roll_h;
    assign pitch_h = to_hund(tp_reg, ati_pkg::PITCH_LIM);
    assign roll_h  = to_hund(tr_reg, ati_pkg::ROLL_LIM);
    always_ff @(posedge aclk) begin
        if (en) begin
            pitch2_reg <= pitch_h[14:0];
            roll2_reg  <= roll_h[15:0];
        end
    end

    // q1: squares
    logic [QW-1:0]      psq_reg, rsq_reg;
    logic signed [14:0] pitch3_reg;
    logic signed [15:0] roll3_reg;
    logic signed [29:0] psq_full;
    logic signed [31:0] rsq_full;
    assign psq_full = pitch2_reg * pitch2_reg;
    assign rsq_full = roll2_reg * roll2_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            psq_reg    <= QW'(psq_full);
            rsq_reg    <= QW'(rsq_full);
            pitch3_reg <= pitch2_reg;
            roll3_reg  <= roll2_reg;
        end
    end

    // square root pipeline, one result bit per stage; entry 0 holds the sum
    logic [QW-1:0]      sq_rem_reg   [0:RW];
    logic [RW-1:0]      sq_root_reg  [0:RW];
    logic signed [14:0] sq_pitch_reg [0:RW];
    logic signed [15:0] sq_roll_reg  [0:RW];

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_rem_reg[0]   <= psq_reg + rsq_reg;
            sq_root_reg[0]  <= '0;
            sq_pitch_reg[0] <= pitch3_reg;
            sq_roll_reg[0]  <= roll3_reg;
        end
    end

    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        localparam int B = RW - 1 - k;
        logic [QW-1:0] trial;
        assign trial = (QW'(sq_root_reg[k]) << (B + 1)) | (QW'(1) << (2 * B));
        always_ff @(posedge aclk) begin
            if (en) begin
                sq_pitch_reg[k+1] <= sq_pitch_reg[k];
                sq_roll_reg[k+1]  <= sq_roll_reg[k];
                if (sq_rem_reg[k] >= trial) begin
                    sq_rem_reg[k+1]  <= sq_rem_reg[k] - trial;
                    sq_root_reg[k+1] <= sq_root_reg[k] | (RW'(1) << B);
                end else begin
                    sq_rem_reg[k+1]  <= sq_rem_reg[k];
                    sq_root_reg[k+1] <= sq_root_reg[k];
                end
            end
        end
    end

    // c1: band correction with clamp at zero
    logic [RW-1:0]      inc_raw, c1_inc_reg;
    logic signed [14:0] c1_pitch_reg;
    logic signed [15:0] c1_roll_reg;
    logic               in_band;
    assign inc_raw = sq_root_reg[RW];
    assign in_band = ((inc_raw != '0) && (inc_raw < RW'(low_band_reg)))
                     || (inc_raw > high_band_reg);
    always_ff @(posedge aclk) begin
        if (en) begin
            c1_pitch_reg <= sq_pitch_reg[RW];
            c1_roll_reg  <= sq_roll_reg[RW];
            if (in_band) begin
                c1_inc_reg <= (inc_raw < RW'(offset_reg)) ? '0 : inc_raw - RW'(offset_reg);
            end else begin
                c1_inc_reg <= inc_raw;
            end
        end
    end

    // output stage: fold of large values
    logic [14:0]        out_inc_reg;
    logic signed [14:0] out_pitch_reg;
    logic signed [15:0] out_roll_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            out_pitch_reg <= c1_pitch_reg;
            out_roll_reg  <= c1_roll_reg;
            if (c1_inc_reg > fold_thr_reg) begin
                out_inc_reg <= (c1_inc_reg < fold_amt_reg) ? '0 : c1_inc_reg - fold_amt_reg;
            end else begin
                out_inc_reg <= c1_inc_reg;
            end
        end
    end

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            h1_vld_reg  <= 1'b0;
            h2_vld_reg  <= 1'b0;
            q1_vld_reg  <= 1'b0;
            sq_vld_reg  <= '0;
            c1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            v0_reg      <= s_tvalid;
            v1_reg      <= v0_reg;
            h1_vld_reg  <= pitch_vld;
            h2_vld_reg  <= h1_vld_reg;
            q1_vld_reg  <= h2_vld_reg;
            sq_vld_reg  <= {sq_vld_reg[RW-1:0], q1_vld_reg};
            c1_vld_reg  <= sq_vld_reg[RW];
            out_vld_reg <= c1_vld_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {2'b00, out_inc_reg, out_roll_reg, out_pitch_reg};

endmodule

>>> rtl/ati_cordic.sv
// pipelined vectoring cordic: one rotation per register stage, sideband carried along
module ati_cordic #(
    parameter int W      = 44,
    parameter int STAGES = ati_pkg::DEF_CORDIC_STAGES,
    parameter int SBW    = 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_vld,
    input  logic signed [W-1:0]         x_in,
    input  logic signed [W-1:0]         y_in,
    input  logic [SBW-1:0]              sb_in,
    output logic                        out_vld,
    output logic signed [W-1:0]         x_out,
    output logic signed [ati_pkg::ZW-1:0] z_out,
    output logic [SBW-1:0]              sb_out
);

    logic signed [W-1:0]           x_reg  [0:STAGES];
    logic signed [W-1:0]           y_reg  [0:STAGES];
    logic signed [ati_pkg::ZW-1:0] z_reg  [0:STAGES];
    logic [SBW-1:0]                sb_reg [0:STAGES];
    logic [STAGES:0]               vld_reg;

    // valid bits shift with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[STAGES-1:0], in_vld};
        end
    end

    // quadrant pre-rotation for vectors in the left half plane
    always_ff @(posedge aclk) begin
        if (en) begin
            sb_reg[0] <= sb_in;
            if (x_in < 0) begin
                if (y_in >= 0) begin
                    x_reg[0] <= y_in;
                    y_reg[0] <= -x_in;
                    z_reg[0] <= ati_pkg::DEG90;
                end else begin
                    x_reg[0] <= -y_in;
                    y_reg[0] <= x_in;
                    z_reg[0] <= -ati_pkg::DEG90;
                end
            end else begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                z_reg[0] <= '0;
            end
        end
    end

    // micro-rotations driving y toward zero
    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (en) begin
                sb_reg[i+1] <= sb_reg[i];
                if (y_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ati_pkg::atan_entry(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ati_pkg::atan_entry(i);
                end
            end
        end
    end

    assign out_vld = vld_reg[STAGES];
    assign x_out   = x_reg[STAGES];
    assign z_out   = z_reg[STAGES];
    assign sb_out  = sb_reg[STAGES];

endmodule

>>> rtl/ati_checker.sv
// port-level checks for the tilt block and their binding to it
module ati_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    logic signed [14:0] pitch;
    logic signed [15:0] roll;
    assign pitch = m_tdata[14:0];
    assign roll  = m_tdata[30:15];

    // nothing comes out of reset valid
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a held result does not change
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // input is refused only while a result waits
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    // angles stay within their clamps
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (pitch >= -15'sd9000) && (pitch <= 15'sd9000)
                     && (roll >= -16'sd18000) && (roll <= 16'sd18000))
        else $error("angle out of range");

endmodule

bind accel_tilt_inclination ati_checker u_ati_checker (.*);

>>> test/tb_accel_tilt_inclination.sv
// testbench for the tilt block: predicts pitch, roll and inclination and checks each result
`timescale 1ns / 1ps

module tb_accel_tilt_inclination;

    localparam int STAGES = 16;
    localparam int LAT = 2 * STAGES + 25;

    typedef struct packed {
        logic signed [15:0] az;
        logic signed [15:0] ay;
        logic signed [15:0] ax;
    } sample_t;

    typedef struct packed {
        logic [14:0]        incl;
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
    } tilt_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [47:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic cfg_wr_en = 1'b0;
    logic [ati_pkg::CFG_AW-1:0] cfg_addr = '0;
    logic [ati_pkg::CFG_W-1:0] cfg_wdata = '0;

    // predictor copy of the registers
    logic [10:0] p_offset = ati_pkg::RST_OFFSET;
    logic [13:0] p_low = ati_pkg::RST_LOW_BAND;
    logic [14:0] p_high = ati_pkg::RST_HIGH_BAND;
    logic [14:0] p_fthr = ati_pkg::RST_FOLD_THR;
    logic [14:0] p_famt = ati_pkg::RST_FOLD_AMT;

    sample_t pending_samples[$];
    tilt_t   expected_tilts[$];
    int      errors = 0;
    bit      quiet = 1'b0;     // no random idling in this stretch
    bit      hold_off = 1'b0;  // receiver stalls for a long stretch
    bit      idle_in = 1'b0;
    bit      idle_out = 1'b0;
    bit      in_taken = 1'b0;  // offered item was accepted at the last rising edge

    accel_tilt_inclination u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // arithmetic shift right with floor
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    // vectoring rotation: angle in degrees*2^16, magnitude returned in mag
    function automatic longint vector_angle(longint xi, longint yi, output longint mag);
        longint x, y, z, t, dx, dy;
        x = xi; y = yi; z = 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = y; y = -x; x = t; z = ati_pkg::DEG90;
            end else begin
                t = -y; y = x; x = t; z = -ati_pkg::DEG90;
            end
        end
        for (int i = 0; i < STAGES; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += ati_pkg::atan_entry(i);
            end else begin
                x -= dx; y += dy; z -= ati_pkg::atan_entry(i);
            end
        end
        mag = x;
        return z;
    endfunction

    function automatic longint hundredths(longint z, longint lim);
        longint t, m, h;
        t = z * 100;
        m = (t < 0) ? -t : t;
        h = (m + 32768) >> 16;
        if (h > lim) h = lim;
        return (t < 0) ? -h : h;
    endfunction

    function automatic longint int_root(longint v);
        longint r;
        r = 0;
        while ((r + 1) * (r + 1) <= v) r++;
        return r;
    endfunction

    function automatic tilt_t predict_tilt(sample_t s);
        longint ax, ay, az, rmag, pmag, zr, zp, pitch, roll, inc;
        tilt_t o;
        ax = s.ax; ay = s.ay; az = s.az;
        zr = 0; zp = 0; rmag = 0;
        if (ay != 0 || az != 0) begin
            zr = vector_angle(az <<< ati_pkg::IN_SCALE, ay <<< ati_pkg::IN_SCALE, rmag);
        end
        if (ax != 0 || rmag != 0) zp = vector_angle(rmag, -ax * 27628053, pmag);
        pitch = hundredths(zp, 9000);
        roll = hundredths(zr, 18000);
        inc = int_root(pitch * pitch + roll * roll);
        if ((inc > 0 && inc < p_low) || inc > p_high) inc -= p_offset;
        if (inc < 0) inc = 0;
        if (inc > p_fthr) begin
            inc -= p_famt;
            if (inc < 0) inc = 0;
        end
        o.pitch = pitch[14:0];
        o.roll = roll[15:0];
        o.incl = inc[14:0];
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        errors++;
    endtask

    // driver: offers queued items, idling at random
    always @(negedge aclk) begin
        idle_in = !quiet && ($urandom_range(99) < 31);
        if (aresetn && (!s_tvalid || in_taken)) begin
            if (pending_samples.size() > 0 && !idle_in) begin
                s_tdata <= pending_samples[0];
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        idle_out = !quiet && ($urandom_range(99) < 31);
        m_tready <= aresetn && !hold_off && !idle_out;
    end

    // acceptance at the rising edge: predict on input, check on output
    always @(posedge aclk) begin
        tilt_t got, want;
        in_taken = aresetn && s_tvalid && s_tready;
        if (in_taken) begin
            expected_tilts.push_back(predict_tilt(pending_samples.pop_front()));
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_tilts.size() == 0) begin
                report_mismatch("unexpected item", 1, 0);
            end else begin
                want = expected_tilts.pop_front();
                if (got.pitch !== want.pitch) report_mismatch("pitch", got.pitch, want.pitch);
                if (got.roll !== want.roll) report_mismatch("roll", got.roll, want.roll);
                if (got.incl !== want.incl) report_mismatch("inclination", got.incl, want.incl);
            end
        end
    end

    task automatic write_reg(logic [ati_pkg::CFG_AW-1:0] idx, int val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val[ati_pkg::CFG_W-1:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            ati_pkg::REG_OFFSET:    p_offset = val[10:0];
            ati_pkg::REG_LOW_BAND:  p_low = val[13:0];
            ati_pkg::REG_HIGH_BAND: p_high = val[14:0];
            ati_pkg::REG_FOLD_THR:  p_fthr = val[14:0];
            ati_pkg::REG_FOLD_AMT:  p_famt = val[14:0];
            default: ;
        endcase
    endtask

    task automatic drain;
        while (pending_samples.size() > 0 || expected_tilts.size() > 0) @(posedge aclk);
        repeat (LAT + 5) @(posedge aclk);
    endtask

    task automatic add_sample(int x, int y, int z);
        sample_t s;
        s.ax = 16'(x); s.ay = 16'(y); s.az = 16'(z);
        pending_samples.push_back(s);
    endtask

    function automatic int rand_axis();
        case ($urandom_range(4))
            0: return $signed(16'($urandom));
            1: return $signed(16'($urandom_range(0, 15))) - 8;
            2: return ($urandom_range(1)) ? 32767 : -32768;
            default: return int'($urandom_range(0, 8000)) - 4000;
        endcase
    endfunction

    task automatic random_phase(int n);
        int x, y, z, g;
        for (int i = 0; i < n; i++) begin
            x = rand_axis(); y = rand_axis(); z = rand_axis();
            // roughly 1 g samples near level, reaching the correction bands
            if ($urandom_range(2) == 0) begin
                g = 16384;
                x = int'($urandom_range(0, 6000)) - 3000;
                y = int'($urandom_range(0, 6000)) - 3000;
                z = ($urandom_range(3) == 0) ? -g : g;
            end
            add_sample(x, y, z);
        end
    endtask

    initial begin
        int sets[4][5];
        sets[0] = '{0, 0, 0, 0, 0};
        sets[1] = '{2047, 16383, 32767, 32767, 32767};
        sets[2] = '{2000, 9000, 20200, 20200, 18000};
        sets[3] = '{300, 4000, 5000, 6000, 15000};
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: zero vectors, extremes, each quadrant, band edges
        quiet = 1'b1;
        add_sample(0, 0, 0);
        add_sample(5, 0, 0);
        add_sample(-5, 0, 0);
        add_sample(0, 0, 100);
        add_sample(0, 0, -100);
        add_sample(0, 100, 0);
        add_sample(0, -100, 0);
        add_sample(32767, 32767, 32767);
        add_sample(-32768, -32768, -32768);
        add_sample(-32768, 32767, -32768);
        add_sample(32767, -32768, 1);
        add_sample(0, -1, -32768);
        add_sample(0, 1, -32768);
        add_sample(100, 200, 16384);
        add_sample(-1000, 1000, 16384);
        add_sample(3000, -2000, 16000);
        add_sample(16384, 0, 1);
        add_sample(1, 1, 1);
        add_sample(-1, -1, -1);
        add_sample(12000, -12000, -8000);
        drain();
        quiet = 1'b0;

        random_phase(400);
        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
        join_none
        drain();

        foreach (sets[k]) begin
            for (int r = 0; r < 5; r++) write_reg(r[ati_pkg::CFG_AW-1:0], sets[k][r]);
            if (k == 3) quiet = 1'b1;
            random_phase(k == 3 ? 200 : 350);
            drain();
            quiet = 1'b0;
        end
        write_reg(ati_pkg::REG_OFFSET, 500);
        write_reg(ati_pkg::REG_LOW_BAND, 1500);
        write_reg(ati_pkg::REG_HIGH_BAND, 8500);
        write_reg(ati_pkg::REG_FOLD_THR, 9500);
        write_reg(ati_pkg::REG_FOLD_AMT, 9000);
        random_phase(200);
        drain();

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

endmodule
